FILE: hdl/sam_pkg.sv
// Package: sizes, memory row types, store request/response bundles and modulo helpers.
package sam_pkg;

	localparam int MAX_NODES = 4096;
	localparam int ALPHABET  = 11;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = NODE_W + 1;
	localparam int SYM_W     = 4;
	localparam int MOD_W     = 11;
	localparam int DIGIT_W   = 4;

	localparam logic [MOD_W-1:0]   MODULUS   = MOD_W'(2012);
	localparam logic [SYM_W-1:0]   SEPARATOR = SYM_W'(10);
	localparam logic [DIGIT_W-1:0] RADIX     = DIGIT_W'(10);
	// floor(2^22 / 2012), used to estimate a quotient by the modulus.
	localparam logic [11:0]        MOD_RECIP = 12'd2084;

	typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

	typedef struct packed {
		logic [NODE_W-1:0] link;
		logic [NODE_W-1:0] len;
	} node_t;

	typedef struct packed {
		logic [MOD_W-1:0] cnt;
		logic [MOD_W-1:0] sum;
	} pm_t;

	typedef struct packed {
		logic [MOD_W-1:0] total;
		logic             overflow;
	} res_t;

	typedef struct packed {
		logic [NODE_W-1:0] tr_raddr;
		logic              tr_we;
		logic [NODE_W-1:0] tr_waddr;
		row_t              tr_wdata;
		logic [NODE_W-1:0] nd_raddr;
		logic              nd_we;
		logic [NODE_W-1:0] nd_waddr;
		node_t             nd_wdata;
		logic [NODE_W-1:0] pm_raddr;
		logic              pm_we;
		logic [NODE_W-1:0] pm_waddr;
		pm_t               pm_wdata;
		logic [NODE_W-1:0] so_raddr;
		logic              so_we;
		logic [NODE_W-1:0] so_waddr;
		logic [NODE_W-1:0] so_wdata;
		logic [CNT_W-1:0]  bk_raddr;
		logic              bk_we;
		logic [CNT_W-1:0]  bk_waddr;
		logic [CNT_W-1:0]  bk_wdata;
	} store_req_t;

	typedef struct packed {
		row_t              tr_rdata;
		node_t             nd_rdata;
		pm_t               pm_rdata;
		logic [NODE_W-1:0] so_rdata;
		logic [CNT_W-1:0]  bk_rdata;
	} store_rsp_t;

	// Sum of two residues, reduced once.
	function automatic logic [MOD_W-1:0] mod_add(input logic [MOD_W-1:0] a,
		input logic [MOD_W-1:0] b);
		logic [MOD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, MODULUS}) begin
			s = s - {1'b0, MODULUS};
		end
		return s[MOD_W-1:0];
	endfunction

endpackage

FILE: hdl/sam_if.sv
// Stream interfaces for the symbol input and the result output.
interface sam_in_if;
	logic                      valid;
	logic                      ready;
	logic [sam_pkg::SYM_W-1:0] symbol;
	logic                      last;
	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

interface sam_out_if;
	logic                      valid;
	logic                      ready;
	logic [sam_pkg::MOD_W-1:0] total;
	logic                      overflow;
	modport source (output valid, output total, output overflow, input ready);
	modport sink (input valid, input total, input overflow, output ready);
endinterface

FILE: hdl/sam_store.sv
// Memories of the automaton: transition rows, node links and lengths, path sums, sort order, buckets.
module sam_store (
	input  logic                  clk,
	input  sam_pkg::store_req_t   req,
	output sam_pkg::store_rsp_t   rsp
);
	import sam_pkg::*;

	row_t              tr_mem [0:MAX_NODES-1];
	node_t             nd_mem [0:MAX_NODES-1];
	pm_t               pm_mem [0:MAX_NODES-1];
	logic [NODE_W-1:0] so_mem [0:MAX_NODES-1];
	logic [CNT_W-1:0]  bk_mem [0:MAX_NODES];

	always_ff @(posedge clk) begin
		if (req.tr_we) begin
			tr_mem[req.tr_waddr] <= req.tr_wdata;
		end
		rsp.tr_rdata <= tr_mem[req.tr_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.nd_we) begin
			nd_mem[req.nd_waddr] <= req.nd_wdata;
		end
		rsp.nd_rdata <= nd_mem[req.nd_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.pm_we) begin
			pm_mem[req.pm_waddr] <= req.pm_wdata;
		end
		rsp.pm_rdata <= pm_mem[req.pm_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.so_we) begin
			so_mem[req.so_waddr] <= req.so_wdata;
		end
		rsp.so_rdata <= so_mem[req.so_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.bk_we) begin
			bk_mem[req.bk_waddr] <= req.bk_wdata;
		end
		rsp.bk_rdata <= bk_mem[req.bk_raddr];
	end

endmodule

FILE: hdl/sam_seq.sv
// Sequencer: automaton extension, length sort, path summation and row clearing.
module sam_seq (
	input  logic                clk,
	input  logic                arst_n,
	sam_in_if.sink              req,
	output sam_pkg::store_req_t mem_req,
	input  sam_pkg::store_rsp_t mem_rsp,
	output logic                res_load,
	output sam_pkg::res_t       res,
	input  logic                res_busy
);
	import sam_pkg::*;

	localparam logic [4:0] ST_CLR  = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] ST_W1   = 5'd2;
	localparam logic [4:0] ST_Q    = 5'd3;
	localparam logic [4:0] ST_C1   = 5'd4;
	localparam logic [4:0] ST_C2   = 5'd5;
	localparam logic [4:0] ST_R2   = 5'd6;
	localparam logic [4:0] ST_FIN  = 5'd7;
	localparam logic [4:0] ST_BZ   = 5'd8;
	localparam logic [4:0] ST_CA   = 5'd9;
	localparam logic [4:0] ST_CB   = 5'd10;
	localparam logic [4:0] ST_CC   = 5'd11;
	localparam logic [4:0] ST_PA   = 5'd12;
	localparam logic [4:0] ST_PB   = 5'd13;
	localparam logic [4:0] ST_SA   = 5'd14;
	localparam logic [4:0] ST_SB   = 5'd15;
	localparam logic [4:0] ST_SC   = 5'd16;
	localparam logic [4:0] ST_ZA   = 5'd17;
	localparam logic [4:0] ST_UA   = 5'd18;
	localparam logic [4:0] ST_UB   = 5'd19;
	localparam logic [4:0] ST_UC   = 5'd20;
	localparam logic [4:0] ST_UD   = 5'd21;
	localparam logic [4:0] ST_UE   = 5'd22;
	localparam logic [4:0] ST_VA   = 5'd23;
	localparam logic [4:0] ST_VB   = 5'd24;
	localparam logic [4:0] ST_OUT  = 5'd25;

	logic [4:0]         state_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   node_cnt_q;
	logic [CNT_W-1:0]   clr_lim_q;
	logic [NODE_W-1:0]  last_node_q;
	logic               ovf_q;
	logic [SYM_W-1:0]   sym_q;
	logic               fin_q;
	logic [NODE_W-1:0]  p_q;
	logic [NODE_W-1:0]  cur_q;
	logic [NODE_W-1:0]  q_q;
	logic [NODE_W-1:0]  nq_q;
	logic [NODE_W-1:0]  v_q;
	logic [NODE_W-1:0]  lencur_q;
	logic [NODE_W-1:0]  lenp_q;
	logic [NODE_W-1:0]  lenq_q;
	logic               first_q;
	logic [CNT_W-1:0]   lenb_q;
	logic [CNT_W-1:0]   acc_q;
	logic [NODE_W-1:0]  u_q;
	row_t               row_q;
	logic [MOD_W-1:0]   cu_q;
	logic [MOD_W-1:0]   su10_q;
	logic [MOD_W-1:0]   ccu_q;
	logic [DIGIT_W-1:0] c_q;
	logic [14:0]        x_q;
	logic [26:0]        prod_q;
	logic [MOD_W-1:0]   total_q;

	node_t              nd;
	row_t               row;
	pm_t                pm;
	logic [NODE_W-1:0]  lencur_w;
	logic [NODE_W-1:0]  edge_w;
	logic [CNT_W-1:0]   n_last;
	logic [14:0]        rem_w;
	logic               take;

	assign nd       = mem_rsp.nd_rdata;
	assign row      = mem_rsp.tr_rdata;
	assign pm       = mem_rsp.pm_rdata;
	assign lencur_w = first_q ? (nd.len + NODE_W'(1)) : lencur_q;
	assign edge_w   = row[sym_q];
	assign n_last   = node_cnt_q - CNT_W'(1);
	assign req.ready = (state_q == ST_IDLE);
	assign take     = req.valid && (state_q == ST_IDLE);
	assign res_load = (state_q == ST_OUT) && !res_busy;
	assign res.total    = total_q;
	assign res.overflow = ovf_q;

	// Remainder of x_q by the modulus from the estimated quotient; at most one fix-up.
	always_comb begin
		rem_w = x_q - 15'(prod_q[26:22] * 15'(MODULUS));
		if (rem_w >= 15'(MODULUS)) begin
			rem_w = rem_w - 15'(MODULUS);
		end
	end

	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				mem_req.tr_raddr = last_node_q;
				mem_req.nd_raddr = last_node_q;
			end
			ST_W1: begin
				if (edge_w != '0) begin
					mem_req.tr_raddr = edge_w;
					mem_req.nd_raddr = edge_w;
				end else begin
					mem_req.tr_we           = 1'b1;
					mem_req.tr_waddr        = p_q;
					mem_req.tr_wdata        = row;
					mem_req.tr_wdata[sym_q] = cur_q;
					if (p_q != '0) begin
						mem_req.tr_raddr = nd.link;
						mem_req.nd_raddr = nd.link;
					end else begin
						mem_req.nd_we    = 1'b1;
						mem_req.nd_waddr = cur_q;
						mem_req.nd_wdata = '{link: '0, len: lencur_w};
					end
				end
			end
			ST_Q: begin
				mem_req.nd_we = 1'b1;
				if (lenp_q + NODE_W'(1) == nd.len) begin
					mem_req.nd_waddr = cur_q;
					mem_req.nd_wdata = '{link: q_q, len: lencur_q};
				end else begin
					mem_req.tr_we    = 1'b1;
					mem_req.tr_waddr = node_cnt_q[NODE_W-1:0];
					mem_req.tr_wdata = row;
					mem_req.nd_waddr = node_cnt_q[NODE_W-1:0];
					mem_req.nd_wdata = '{link: nd.link, len: lenp_q + NODE_W'(1)};
				end
			end
			ST_C1: begin
				mem_req.nd_we    = 1'b1;
				mem_req.nd_waddr = cur_q;
				mem_req.nd_wdata = '{link: nq_q, len: lencur_q};
			end
			ST_C2: begin
				mem_req.nd_we    = 1'b1;
				mem_req.nd_waddr = q_q;
				mem_req.nd_wdata = '{link: nq_q, len: lenq_q};
				mem_req.tr_raddr = p_q;
				mem_req.nd_raddr = p_q;
			end
			ST_R2: begin
				if (edge_w == q_q) begin
					mem_req.tr_we           = 1'b1;
					mem_req.tr_waddr        = p_q;
					mem_req.tr_wdata        = row;
					mem_req.tr_wdata[sym_q] = nq_q;
					mem_req.tr_raddr        = nd.link;
					mem_req.nd_raddr        = nd.link;
				end
			end
			ST_BZ: begin
				mem_req.bk_we    = 1'b1;
				mem_req.bk_waddr = i_q;
				mem_req.bk_wdata = '0;
			end
			ST_CA: mem_req.nd_raddr = i_q[NODE_W-1:0];
			ST_CB: mem_req.bk_raddr = CNT_W'(nd.len) + CNT_W'(1);
			ST_CC: begin
				mem_req.bk_we    = 1'b1;
				mem_req.bk_waddr = lenb_q;
				mem_req.bk_wdata = mem_rsp.bk_rdata + CNT_W'(1);
			end
			ST_PA: mem_req.bk_raddr = i_q;
			ST_PB: begin
				mem_req.bk_we    = 1'b1;
				mem_req.bk_waddr = i_q;
				mem_req.bk_wdata = acc_q + mem_rsp.bk_rdata;
			end
			ST_SA: mem_req.nd_raddr = i_q[NODE_W-1:0];
			ST_SB: mem_req.bk_raddr = CNT_W'(nd.len);
			ST_SC: begin
				mem_req.so_we    = 1'b1;
				mem_req.so_waddr = mem_rsp.bk_rdata[NODE_W-1:0];
				mem_req.so_wdata = i_q[NODE_W-1:0];
				mem_req.bk_we    = 1'b1;
				mem_req.bk_waddr = lenb_q;
				mem_req.bk_wdata = mem_rsp.bk_rdata + CNT_W'(1);
			end
			ST_ZA: begin
				mem_req.pm_we    = 1'b1;
				mem_req.pm_waddr = i_q[NODE_W-1:0];
				mem_req.pm_wdata = '{cnt: (i_q == '0) ? MOD_W'(1) : '0, sum: '0};
			end
			ST_UA: mem_req.so_raddr = i_q[NODE_W-1:0];
			ST_UB: begin
				mem_req.pm_raddr = mem_rsp.so_rdata;
				mem_req.tr_raddr = mem_rsp.so_rdata;
			end
			ST_VA: begin
				if (c_q != RADIX) begin
					mem_req.pm_raddr = row_q[c_q];
				end
			end
			ST_VB: begin
				mem_req.pm_we    = 1'b1;
				mem_req.pm_waddr = v_q;
				mem_req.pm_wdata = '{cnt: mod_add(pm.cnt, cu_q),
					sum: mod_add(mod_add(pm.sum, su10_q), ccu_q)};
			end
			ST_CLR: begin
				mem_req.tr_we    = 1'b1;
				mem_req.tr_waddr = i_q[NODE_W-1:0];
				mem_req.tr_wdata = '0;
				// The root entry holds length zero and no suffix link.
				if (i_q == '0) begin
					mem_req.nd_we    = 1'b1;
					mem_req.nd_waddr = '0;
					mem_req.nd_wdata = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			i_q         <= '0;
			clr_lim_q   <= CNT_W'(MAX_NODES);
			node_cnt_q  <= CNT_W'(1);
			last_node_q <= '0;
			ovf_q       <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					i_q <= i_q + CNT_W'(1);
					if (i_q == clr_lim_q - CNT_W'(1)) begin
						i_q     <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						sym_q   <= req.symbol;
						fin_q   <= req.last;
						p_q     <= last_node_q;
						cur_q   <= node_cnt_q[NODE_W-1:0];
						first_q <= 1'b1;
						state_q <= ST_FIN;
						if (req.symbol <= SEPARATOR && !ovf_q) begin
							if (node_cnt_q + CNT_W'(2) > CNT_W'(MAX_NODES)) begin
								ovf_q <= 1'b1;
							end else begin
								node_cnt_q <= node_cnt_q + CNT_W'(1);
								state_q    <= ST_W1;
							end
						end
					end
				end
				ST_W1: begin
					first_q  <= 1'b0;
					lencur_q <= lencur_w;
					lenp_q   <= nd.len;
					if (edge_w != '0) begin
						q_q     <= edge_w;
						state_q <= ST_Q;
					end else if (p_q != '0) begin
						p_q <= nd.link;
					end else begin
						last_node_q <= cur_q;
						state_q     <= ST_FIN;
					end
				end
				ST_Q: begin
					lenq_q <= nd.len;
					if (lenp_q + NODE_W'(1) == nd.len) begin
						last_node_q <= cur_q;
						state_q     <= ST_FIN;
					end else begin
						nq_q       <= node_cnt_q[NODE_W-1:0];
						node_cnt_q <= node_cnt_q + CNT_W'(1);
						state_q    <= ST_C1;
					end
				end
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_R2;
				ST_R2: begin
					if (edge_w == q_q && p_q != '0) begin
						p_q <= nd.link;
					end else begin
						last_node_q <= cur_q;
						state_q     <= ST_FIN;
					end
				end
				ST_FIN: begin
					i_q <= '0;
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (ovf_q) begin
						total_q <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_BZ;
					end
				end
				ST_BZ: begin
					i_q <= i_q + CNT_W'(1);
					if (i_q == node_cnt_q) begin
						i_q     <= '0;
						state_q <= ST_CA;
					end
				end
				ST_CA: state_q <= ST_CB;
				ST_CB: begin
					lenb_q  <= CNT_W'(nd.len) + CNT_W'(1);
					state_q <= ST_CC;
				end
				ST_CC: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= ST_CA;
					if (i_q == n_last) begin
						i_q     <= CNT_W'(1);
						acc_q   <= '0;
						state_q <= ST_PA;
					end
				end
				ST_PA: state_q <= ST_PB;
				ST_PB: begin
					acc_q   <= acc_q + mem_rsp.bk_rdata;
					i_q     <= i_q + CNT_W'(1);
					state_q <= ST_PA;
					if (i_q == node_cnt_q) begin
						i_q     <= '0;
						state_q <= ST_SA;
					end
				end
				ST_SA: state_q <= ST_SB;
				ST_SB: begin
					lenb_q  <= CNT_W'(nd.len);
					state_q <= ST_SC;
				end
				ST_SC: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= ST_SA;
					if (i_q == n_last) begin
						i_q     <= '0;
						state_q <= ST_ZA;
					end
				end
				ST_ZA: begin
					i_q <= i_q + CNT_W'(1);
					if (i_q == n_last) begin
						i_q     <= '0;
						total_q <= '0;
						state_q <= ST_UA;
					end
				end
				ST_UA: state_q <= ST_UB;
				ST_UB: begin
					u_q     <= mem_rsp.so_rdata;
					state_q <= ST_UC;
				end
				ST_UC: begin
					row_q   <= row;
					cu_q    <= pm.cnt;
					x_q     <= {pm.sum, 3'b000} + {3'b000, pm.sum, 1'b0};
					total_q <= mod_add(total_q, pm.sum);
					// The root takes no edge on digit zero.
					if (u_q == '0) begin
						c_q   <= DIGIT_W'(1);
						ccu_q <= pm.cnt;
					end else begin
						c_q   <= '0;
						ccu_q <= '0;
					end
					state_q <= ST_UD;
				end
				ST_UD: begin
					prod_q  <= 27'(x_q * MOD_RECIP);
					state_q <= ST_UE;
				end
				ST_UE: begin
					su10_q  <= rem_w[MOD_W-1:0];
					state_q <= ST_VA;
				end
				ST_VA: begin
					if (c_q == RADIX) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= (i_q == n_last) ? ST_OUT : ST_UA;
					end else if (row_q[c_q] != '0) begin
						v_q     <= row_q[c_q];
						state_q <= ST_VB;
					end else begin
						c_q   <= c_q + DIGIT_W'(1);
						ccu_q <= mod_add(ccu_q, cu_q);
					end
				end
				ST_VB: begin
					c_q     <= c_q + DIGIT_W'(1);
					ccu_q   <= mod_add(ccu_q, cu_q);
					state_q <= ST_VA;
				end
				ST_OUT: begin
					if (!res_busy) begin
						clr_lim_q   <= node_cnt_q;
						node_cnt_q  <= CNT_W'(1);
						last_node_q <= '0;
						ovf_q       <= 1'b0;
						i_q         <= '0;
						state_q     <= ST_CLR;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/suffix_automaton_digit_substring_sum.sv
// Each symbol item (digit 0 to 9, or 10 as separator) extends a suffix automaton held in
// on-chip memories with registered reads; the work per item grows with each suffix link
// followed, with an existing edge that is found, and with a cloned node and each link
// redirected to it. After the item marked last the block sorts the nodes by length,
// sums paths over every node and digit edge, emits one result item (total modulo 2012,
// overflow), and then clears the transition rows of the nodes used, one row per cycle.
// After reset that clearing pass runs over all 4096 rows before the first item is taken.
// A set that would exceed the node capacity reports overflow with a total of zero.
module suffix_automaton_digit_substring_sum (
	input  logic      clk,
	input  logic      arst_n,
	sam_in_if.sink    req,
	sam_out_if.source rsp
);
	import sam_pkg::*;

	store_req_t mem_req;
	store_rsp_t mem_rsp;
	logic       res_load;
	res_t       res;
	logic       res_valid_q;
	res_t       res_q;

	sam_store u_store (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

	sam_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.mem_req  (mem_req),
		.mem_rsp  (mem_rsp),
		.res_load (res_load),
		.res      (res),
		.res_busy (res_valid_q)
	);

	// Output register: the result item waits here while new symbols are taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign rsp.valid    = res_valid_q;
	assign rsp.total    = res_q.total;
	assign rsp.overflow = res_q.overflow;

endmodule

FILE: tb/suffix_automaton_digit_substring_sum_tb.sv
// Testbench: random and directed digit sets checked against a built-in automaton predictor.
`timescale 1ns / 100ps

module suffix_automaton_digit_substring_sum_tb;
	import sam_pkg::*;

	localparam int IDLE_LIMIT = 400000;
	localparam int NUM_MOD    = 2012;
	localparam int SEP_SYM    = 10;

	logic clk;
	logic arst_n;

	sam_in_if  req();
	sam_out_if rsp();

	suffix_automaton_digit_substring_sum DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Predictor state: a software copy of the automaton.
	int unsigned edges [MAX_NODES*ALPHABET];
	int unsigned links [MAX_NODES];
	int unsigned lens  [MAX_NODES];
	int unsigned nodes_used;
	int unsigned tail_node;
	bit          capacity_hit;

	res_t expected_totals [$];
	int   error_count;
	int   idle_cycles;
	bit   gaps_on;

	always #5 clk = ~clk;

	function automatic int draw_wait();
		return gaps_on ? $urandom_range(0, 12) : 0;
	endfunction

	function automatic void automaton_clear();
		for (int i = 0; i < nodes_used * ALPHABET; i++) begin
			edges[i] = 0;
		end
		nodes_used   = 1;
		tail_node    = 0;
		capacity_hit = 0;
		lens[0]      = 0;
		links[0]     = 0;
	endfunction

	function automatic void automaton_extend(input int unsigned x);
		int unsigned cur;
		int unsigned p;
		int unsigned q;
		int unsigned nq;
		bit          found;
		cur = nodes_used++;
		p = tail_node;
		found = 0;
		lens[cur] = lens[p] + 1;
		links[cur] = 0;
		forever begin
			if (edges[p*ALPHABET + x] != 0) begin
				found = 1;
				break;
			end
			edges[p*ALPHABET + x] = cur;
			if (p == 0) break;
			p = links[p];
		end
		tail_node = cur;
		if (!found) return;
		q = edges[p*ALPHABET + x];
		if (lens[p] + 1 == lens[q]) begin
			links[cur] = q;
			return;
		end
		nq = nodes_used++;
		for (int c = 0; c < ALPHABET; c++) begin
			edges[nq*ALPHABET + c] = edges[q*ALPHABET + c];
		end
		links[nq] = links[q];
		lens[nq] = lens[p] + 1;
		links[cur] = nq;
		links[q] = nq;
		forever begin
			if (edges[p*ALPHABET + x] != q) break;
			edges[p*ALPHABET + x] = nq;
			if (p == 0) break;
			p = links[p];
		end
	endfunction

	// Sum of all distinct numbers without leading zeros, modulo 2012.
	function automatic int unsigned substring_sum();
		int unsigned bucket [MAX_NODES+1];
		int unsigned order  [MAX_NODES];
		int unsigned cnt    [MAX_NODES];
		int unsigned acc    [MAX_NODES];
		int unsigned n;
		int unsigned u;
		int unsigned v;
		int unsigned total;
		n = nodes_used;
		total = 0;
		for (int i = 0; i <= n; i++) bucket[i] = 0;
		for (int i = 0; i < n; i++) bucket[lens[i] + 1]++;
		for (int i = 1; i <= n; i++) bucket[i] += bucket[i-1];
		for (int i = 0; i < n; i++) order[bucket[lens[i]]++] = i;
		for (int i = 0; i < n; i++) begin
			cnt[i] = 0;
			acc[i] = 0;
		end
		cnt[0] = 1;
		for (int i = 0; i < n; i++) begin
			u = order[i];
			for (int c = (u == 0) ? 1 : 0; c < 10; c++) begin
				v = edges[u*ALPHABET + c];
				if (v == 0) continue;
				cnt[v] = (cnt[v] + cnt[u]) % NUM_MOD;
				acc[v] = (acc[v] + acc[u] * 10 + c * cnt[u]) % NUM_MOD;
			end
			total = (total + acc[u]) % NUM_MOD;
		end
		return total;
	endfunction

	function automatic void predict_symbol(input int unsigned sym, input bit lst);
		res_t r;
		if (sym <= SEP_SYM && !capacity_hit) begin
			if (nodes_used + 2 > MAX_NODES) capacity_hit = 1;
			else automaton_extend(sym);
		end
		if (lst) begin
			r.overflow = capacity_hit;
			r.total    = capacity_hit ? '0 : MOD_W'(substring_sum());
			expected_totals.push_back(r);
			automaton_clear();
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic send_symbol(input int unsigned sym, input bit lst);
		int n;
		n = draw_wait();
		if (n > 0) begin
			req.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		req.valid  <= 1'b1;
		req.symbol <= SYM_W'(sym);
		req.last   <= lst;
		do @(posedge clk); while (!req.ready);
		predict_symbol(sym, lst);
	endtask

	task automatic send_set(input int unsigned syms [$]);
		foreach (syms[i]) send_symbol(syms[i], i == syms.size() - 1);
	endtask

	task automatic test_directed();
		gaps_on = 1;
		send_set('{15});
		send_set('{0});
		send_set('{9});
		send_set('{1, 2, 3});
		send_set('{1, 10, 1, 2});
		send_set('{12, 11, 5, 13, 14});
		send_set('{0, 0, 1, 0, 0, 10, 9, 9, 9});
		gaps_on = 0;
		send_set('{1, 2, 1, 2, 1, 10, 2, 1, 2, 10, 15});
		send_set('{10});
		send_set('{9, 8, 7, 6, 5, 4, 3, 2, 1, 0});
	endtask

	task automatic test_random_sets();
		int unsigned syms [$];
		int sent;
		int len;
		int k;
		sent = 0;
		while (sent < 1100) begin
			gaps_on = $urandom_range(0, 3) != 0;
			len = $urandom_range(1, 40);
			syms.delete();
			for (int i = 0; i < len; i++) begin
				k = $urandom_range(0, 99);
				if (k < 4) syms.push_back($urandom_range(11, 15));
				else if (k < 14) syms.push_back(SEP_SYM);
				else if (k < 30) syms.push_back($urandom_range(0, 2));
				else syms.push_back($urandom_range(0, 9));
			end
			send_set(syms);
			sent += len;
		end
	endtask

	task automatic test_capacity();
		gaps_on = 0;
		while (!capacity_hit) send_symbol($urandom_range(0, 10), 1'b0);
		repeat (5) send_symbol($urandom_range(0, 10), 1'b0);
		send_symbol(7, 1'b1);
		gaps_on = 1;
		send_set('{4, 2});
	endtask

	// Result side: random stalls before each item while gaps are on.
	initial begin
		int n;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = draw_wait();
			if (n > 0) begin
				rsp.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	always @(posedge clk) begin
		res_t e;
		if (rsp.valid && rsp.ready) begin
			if (expected_totals.size() == 0) begin
				report_mismatch("result item with none expected");
			end else begin
				e = expected_totals.pop_front();
				if (rsp.total !== e.total)
					report_mismatch($sformatf("total %0d, expected %0d", rsp.total, e.total));
				if (rsp.overflow !== e.overflow)
					report_mismatch($sformatf("overflow %0b, expected %0b",
						rsp.overflow, e.overflow));
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		req.valid   = 1'b0;
		req.symbol  = '0;
		req.last    = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		gaps_on     = 1;
		nodes_used  = MAX_NODES;
		automaton_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_sets();
		test_capacity();
		req.valid <= 1'b0;
		while (expected_totals.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/sam_pkg.sv
hdl/sam_if.sv
hdl/sam_store.sv
hdl/sam_seq.sv
hdl/suffix_automaton_digit_substring_sum.sv
tb/suffix_automaton_digit_substring_sum_tb.sv
